/* rtl/dclab_pkg.sv */
package dclab_pkg;

  // Fixed widths of the port fields.
  localparam int OUT_W     = 11;
  localparam int IDX_W     = 10;
  localparam int CODE_W    = 2;
  localparam int EPS_W     = 34;
  localparam int MINP_W    = 11;
  localparam int CFG_IDX_W = 1;

  // Register reset values.
  localparam logic [EPS_W-1:0]  EPS_RST  = EPS_W'(100);
  localparam logic [MINP_W-1:0] MINP_RST = MINP_W'(4);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_EPS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MINP = 1'b1;

  // Command codes.
  localparam logic [CODE_W-1:0] CMD_ADD  = 2'd0;
  localparam logic [CODE_W-1:0] CMD_LOAD = 2'd1;
  localparam logic [CODE_W-1:0] CMD_RUN  = 2'd2;
  localparam logic [CODE_W-1:0] CMD_READ = 2'd3;

  // Point classes.
  localparam logic [CODE_W-1:0] CLS_UNCL  = 2'd0;
  localparam logic [CODE_W-1:0] CLS_NOISE = 2'd1;
  localparam logic [CODE_W-1:0] CLS_CLUST = 2'd2;

  // Result status codes.
  localparam logic [CODE_W-1:0] ST_OK     = 2'd0;
  localparam logic [CODE_W-1:0] ST_NOISE  = 2'd1;
  localparam logic [CODE_W-1:0] ST_FULL   = 2'd2;
  localparam logic [CODE_W-1:0] ST_BADIDX = 2'd3;

  // Datapath operations, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE, OP_CLR, OP_CAPTURE, OP_STORE, OP_SCAN, OP_NOISE_P, OP_PICK,
    OP_RUN_INIT, OP_RD_P, OP_LD_REF, OP_NEXT_P, OP_ID_NEXT, OP_RD_Q,
    OP_RD_S, OP_RUN_END, OP_RD_IDX, OP_RESP
  } dp_op_t;

  // Kinds of pass over the stored points.
  typedef enum logic [2:0] {
    SC_COUNT, SC_FIND, SC_APPLY, SC_SEED, SC_EXPAND
  } scan_t;

  // Kinds of result.
  typedef enum logic [2:0] {
    RS_DONE, RS_NOISE, RS_FULL, RS_BADIDX, RS_CORE, RS_READ
  } resp_t;

  typedef struct packed {
    dp_op_t op;
    scan_t  scan;
    resp_t  resp;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_busy;
    logic full;
    logic idx_bad;
    logic uncl;
    logic core;
    logic p_done;
    logic q_done;
  } dp_sts_t;

endpackage

/* rtl/dclab_ram.sv */
module dclab_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/dclab_datapath.sv */
module dclab_datapath #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [dclab_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dclab_pkg::EPS_W-1:0]          cfg_wdata,
  input  logic signed [COORD_BITS-1:0]         in_coord_x,
  input  logic signed [COORD_BITS-1:0]         in_coord_y,
  input  logic signed [COORD_BITS-1:0]         in_coord_z,
  input  logic [dclab_pkg::IDX_W-1:0]          in_point_index,
  input  dclab_pkg::dp_cmd_t                   cmd,
  output dclab_pkg::dp_sts_t                   sts,
  output logic                                 out_strobe,
  output logic [dclab_pkg::CODE_W-1:0]         out_status,
  output logic [dclab_pkg::CODE_W-1:0]         out_label_class,
  output logic [dclab_pkg::OUT_W-1:0]          out_cluster_id,
  output logic [dclab_pkg::OUT_W-1:0]          out_cluster_count,
  output logic [dclab_pkg::OUT_W-1:0]          out_point_count
);
  import dclab_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int IDW  = $clog2(MAX_POINTS + 2);
  localparam int LW   = CODE_W + CW;
  localparam int SQW  = 2 * CB + 2;
  localparam int SUMW = SQW + 2;
  localparam int CMPW = (SUMW > EPS_W) ? SUMW : EPS_W;

  // Configuration registers.
  logic [EPS_W-1:0]  eps_r;
  logic [MINP_W-1:0] minp_r;

  // Command and loop registers.
  logic signed [CB-1:0] cap_x_r, cap_y_r, cap_z_r;
  logic signed [CB-1:0] ref_x_r, ref_y_r, ref_z_r;
  logic [IDX_W-1:0]     idx_r;
  logic [CW-1:0]        stored_r, clusters_r, p_r, best_r, cnt_r, qi_r, qlen_r, clr_r;
  logic [IDW-1:0]       id_r;
  logic                 any_r;

  // Scan pipeline.
  logic          scan_busy_r;
  scan_t         mode_r;
  logic [CW-1:0] j_r, j1_r, j2_r;
  logic          v1_r, v2_r;
  logic [SQW-1:0] sqx_r, sqy_r, sqz_r;
  logic [LW-1:0] lab2_r;

  // Result registers.
  logic                 out_strobe_r;
  logic [CODE_W-1:0]    out_status_r, out_class_r;
  logic [CW-1:0]        out_cid_r, out_ccnt_r, out_pcnt_r;

  // Memory ports.
  logic            crd_we, crd_re, lab_we, lab_re, q_re, flg_we;
  logic [IW-1:0]   crd_raddr, lab_waddr, lab_raddr, q_raddr;
  logic [3*CB-1:0] crd_rdata;
  logic [LW-1:0]   lab_wdata, lab_rdata;
  logic [IW-1:0]   q_rdata;
  logic [CW-1:0]   flg_waddr, flg_wdata, flg_rdata;

  logic issue;
  logic signed [CB-1:0] rd_x, rd_y, rd_z;
  logic signed [CB:0]   dx, dy, dz;
  logic [SQW-1:0]       sqx, sqy, sqz;
  logic [SUMW-1:0]      sum2;
  logic                 near2, flag_hit;
  logic [CODE_W-1:0]    cls2;
  logic [CW-1:0]        cl2;
  logic                 s2_lab_we, s2_push, s2_flag_we;
  logic [LW-1:0]        s2_lab_wd;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r  <= EPS_RST;
      minp_r <= MINP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EPS:  eps_r  <= cfg_wdata;
        CFG_MINP: minp_r <= cfg_wdata[MINP_W-1:0];
      endcase
    end
  end

  // Point coordinates, labels, seed queue and merge marks.
  dclab_ram #(.W(3 * CB), .D(MAX_POINTS)) u_coord_ram (
    .clk(clk), .we(crd_we), .waddr(IW'(stored_r)), .wdata({cap_x_r, cap_y_r, cap_z_r}),
    .re(crd_re), .raddr(crd_raddr), .rdata(crd_rdata)
  );
  dclab_ram #(.W(LW), .D(MAX_POINTS)) u_label_ram (
    .clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
    .re(lab_re), .raddr(lab_raddr), .rdata(lab_rdata)
  );
  dclab_ram #(.W(IW), .D(MAX_POINTS)) u_queue_ram (
    .clk(clk), .we(s2_push), .waddr(IW'(qlen_r)), .wdata(IW'(j2_r)),
    .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
  );
  dclab_ram #(.W(CW), .D(MAX_POINTS + 1)) u_flag_ram (
    .clk(clk), .we(flg_we), .waddr(flg_waddr), .wdata(flg_wdata),
    .re(v1_r), .raddr(lab_rdata[CW-1:0]), .rdata(flg_rdata)
  );

  assign issue  = scan_busy_r && (j_r < stored_r);
  assign crd_we = (cmd.op == OP_STORE);
  assign q_re   = (cmd.op == OP_RD_Q);
  assign q_raddr = IW'(qi_r);

  // Read address selection: the scan has the ports while it issues.
  always_comb begin
    crd_re    = 1'b0;
    lab_re    = 1'b0;
    crd_raddr = IW'(j_r);
    lab_raddr = IW'(j_r);
    if (issue) begin
      crd_re = 1'b1;
      lab_re = 1'b1;
    end else begin
      unique case (cmd.op)
        OP_RD_P: begin
          crd_re    = 1'b1;
          lab_re    = 1'b1;
          crd_raddr = IW'(p_r);
          lab_raddr = IW'(p_r);
        end
        OP_RD_S: begin
          crd_re    = 1'b1;
          crd_raddr = q_rdata;
        end
        OP_RD_IDX: begin
          lab_re    = 1'b1;
          lab_raddr = IW'(idx_r);
        end
        default: ;
      endcase
    end
  end

  // Second stage: squared differences against the reference point.
  assign rd_x = crd_rdata[3*CB-1:2*CB];
  assign rd_y = crd_rdata[2*CB-1:CB];
  assign rd_z = crd_rdata[CB-1:0];
  assign dx = {rd_x[CB-1], rd_x} - {ref_x_r[CB-1], ref_x_r};
  assign dy = {rd_y[CB-1], rd_y} - {ref_y_r[CB-1], ref_y_r};
  assign dz = {rd_z[CB-1], rd_z} - {ref_z_r[CB-1], ref_z_r};
  assign sqx = SQW'(dx) * SQW'(dx);
  assign sqy = SQW'(dy) * SQW'(dy);
  assign sqz = SQW'(dz) * SQW'(dz);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
    end
    j1_r   <= j_r;
    j2_r   <= j1_r;
    sqx_r  <= sqx;
    sqy_r  <= sqy;
    sqz_r  <= sqz;
    lab2_r <= lab_rdata;
  end

  // Third stage: neighbour test and the action of the pass.
  assign sum2     = SUMW'(sqx_r) + SUMW'(sqy_r) + SUMW'(sqz_r);
  assign near2    = CMPW'(sum2) <= CMPW'(eps_r);
  assign cls2     = lab2_r[LW-1 -: CODE_W];
  assign cl2      = lab2_r[CW-1:0];
  assign flag_hit = (flg_rdata == stored_r);

  always_comb begin
    s2_lab_we  = 1'b0;
    s2_push    = 1'b0;
    s2_flag_we = 1'b0;
    s2_lab_wd  = {CLS_CLUST, best_r};
    if (v2_r) begin
      unique case (mode_r)
        SC_FIND:  s2_flag_we = near2 && (cls2 == CLS_CLUST);
        SC_APPLY: s2_lab_we  = near2 || ((cls2 == CLS_CLUST) && flag_hit);
        SC_SEED: begin
          s2_lab_we = near2;
          s2_lab_wd = {CLS_CLUST, CW'(id_r)};
          s2_push   = near2 && (j2_r != p_r);
        end
        SC_EXPAND: begin
          s2_lab_we = near2 && ((cls2 == CLS_UNCL) || (cls2 == CLS_NOISE));
          s2_lab_wd = {CLS_CLUST, CW'(id_r)};
          s2_push   = near2 && (cls2 == CLS_UNCL);
        end
        default: ;
      endcase
    end
  end

  // Label write port: store and noise marks come from idle-time operations.
  always_comb begin
    lab_we    = s2_lab_we;
    lab_waddr = IW'(j2_r);
    lab_wdata = s2_lab_wd;
    priority if (cmd.op == OP_STORE) begin
      lab_we    = 1'b1;
      lab_waddr = IW'(stored_r);
      lab_wdata = {CLS_UNCL, CW'(0)};
    end else if (cmd.op == OP_NOISE_P) begin
      lab_we    = 1'b1;
      lab_waddr = IW'(p_r);
      lab_wdata = {CLS_NOISE, CW'(0)};
    end else begin
    end
  end

  // Merge marks: cleared once after reset, then stamped with the store size.
  always_comb begin
    flg_we    = s2_flag_we;
    flg_waddr = cl2;
    flg_wdata = stored_r;
    if (cmd.op == OP_CLR) begin
      flg_we    = 1'b1;
      flg_waddr = clr_r;
      flg_wdata = '0;
    end
  end

  // Loop registers and results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_busy_r  <= 1'b0;
      stored_r     <= '0;
      clusters_r   <= '0;
      clr_r        <= '0;
      qi_r         <= '0;
      qlen_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (issue) begin
        j_r <= j_r + 1'b1;
      end
      if (scan_busy_r && !issue && !v1_r && !v2_r) begin
        scan_busy_r <= 1'b0;
      end
      if (v2_r && (mode_r == SC_COUNT) && near2) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (s2_flag_we) begin
        if (!any_r || (cl2 < best_r)) begin
          best_r <= cl2;
        end
        any_r <= 1'b1;
      end
      if (s2_push) begin
        qlen_r <= qlen_r + 1'b1;
      end
      unique case (cmd.op)
        OP_CLR: clr_r <= clr_r + 1'b1;
        OP_CAPTURE: begin
          cap_x_r <= in_coord_x;
          cap_y_r <= in_coord_y;
          cap_z_r <= in_coord_z;
          ref_x_r <= in_coord_x;
          ref_y_r <= in_coord_y;
          ref_z_r <= in_coord_z;
          idx_r   <= in_point_index;
        end
        OP_STORE: begin
          p_r      <= stored_r;
          stored_r <= stored_r + 1'b1;
        end
        OP_SCAN: begin
          scan_busy_r <= 1'b1;
          j_r         <= '0;
          mode_r      <= cmd.scan;
          if (cmd.scan == SC_COUNT) begin
            cnt_r <= '0;
          end
          if (cmd.scan == SC_FIND) begin
            any_r <= 1'b0;
          end
          if (cmd.scan == SC_SEED) begin
            qlen_r <= '0;
            qi_r   <= '0;
          end
        end
        OP_NOISE_P, OP_NEXT_P: p_r <= p_r + 1'b1;
        OP_PICK: begin
          if (!any_r) begin
            clusters_r <= clusters_r + 1'b1;
            best_r     <= clusters_r + 1'b1;
          end
        end
        OP_RUN_INIT: begin
          p_r  <= '0;
          id_r <= IDW'(1);
        end
        OP_LD_REF: begin
          ref_x_r <= rd_x;
          ref_y_r <= rd_y;
          ref_z_r <= rd_z;
        end
        OP_ID_NEXT: begin
          id_r <= id_r + 1'b1;
          p_r  <= p_r + 1'b1;
        end
        OP_RD_S: qi_r <= qi_r + 1'b1;
        OP_RUN_END: clusters_r <= CW'(id_r - 1'b1);
        OP_RESP: begin
          out_strobe_r <= 1'b1;
          out_ccnt_r   <= clusters_r;
          out_pcnt_r   <= stored_r;
          unique case (cmd.resp)
            RS_NOISE: begin
              out_status_r <= ST_NOISE;
              out_class_r  <= CLS_NOISE;
              out_cid_r    <= '0;
            end
            RS_FULL: begin
              out_status_r <= ST_FULL;
              out_class_r  <= CLS_UNCL;
              out_cid_r    <= '0;
            end
            RS_BADIDX: begin
              out_status_r <= ST_BADIDX;
              out_class_r  <= CLS_UNCL;
              out_cid_r    <= '0;
            end
            RS_CORE: begin
              out_status_r <= ST_OK;
              out_class_r  <= CLS_CLUST;
              out_cid_r    <= best_r;
            end
            RS_READ: begin
              out_status_r <= ST_OK;
              out_class_r  <= lab_rdata[LW-1 -: CODE_W];
              out_cid_r    <= lab_rdata[CW-1:0];
            end
            default: begin
              out_status_r <= ST_OK;
              out_class_r  <= CLS_UNCL;
              out_cid_r    <= '0;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // Status towards the controller.
  always_comb begin
    sts.clr_done  = (clr_r == CW'(MAX_POINTS));
    sts.scan_busy = scan_busy_r;
    sts.full      = (stored_r == CW'(MAX_POINTS));
    sts.idx_bad   = (32'(idx_r) >= 32'(stored_r));
    sts.uncl      = (lab_rdata[LW-1 -: CODE_W] == CLS_UNCL);
    sts.core      = (32'(cnt_r) >= 32'(minp_r));
    sts.p_done    = (p_r == stored_r);
    sts.q_done    = (qi_r == qlen_r);
  end

  assign out_strobe        = out_strobe_r;
  assign out_status        = out_status_r;
  assign out_label_class   = out_class_r;
  assign out_cluster_id    = OUT_W'(out_cid_r);
  assign out_cluster_count = OUT_W'(out_ccnt_r);
  assign out_point_count   = OUT_W'(out_pcnt_r);

  // A result transfer lasts a single cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r) else $error("result strobe held");

  // Scan write-back only ever touches stored points.
  a_scan_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (j2_r < stored_r)) else $error("scan index beyond store");

  // The queue is never read beyond what was written.
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    qi_r <= qlen_r) else $error("seed queue overrun");

  // The store never shrinks.
  a_store_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (stored_r >= $past(stored_r))) else $error("store count fell");

endmodule

/* rtl/dclab_ctrl.sv */
module dclab_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dclab_pkg::CODE_W-1:0] in_command,
  input  dclab_pkg::dp_sts_t          sts,
  output dclab_pkg::dp_cmd_t          cmd,
  output logic                        busy
);
  import dclab_pkg::*;

  typedef enum logic [19:0] {
    S_CLEAR  = 20'h00001,
    S_IDLE   = 20'h00002,
    S_DECODE = 20'h00004,
    S_A_CNT  = 20'h00008,
    S_A_CW   = 20'h00010,
    S_A_FW   = 20'h00020,
    S_A_AP   = 20'h00040,
    S_A_AW   = 20'h00080,
    S_R_TEST = 20'h00100,
    S_R_LD   = 20'h00200,
    S_R_CNT  = 20'h00400,
    S_R_CW   = 20'h00800,
    S_R_SW   = 20'h01000,
    S_R_QT   = 20'h02000,
    S_R_QS   = 20'h04000,
    S_R_QL   = 20'h08000,
    S_R_QC   = 20'h10000,
    S_R_QCW  = 20'h20000,
    S_R_QEW  = 20'h40000,
    S_RESP   = 20'h80000
  } state_t;

  state_t            state_r, state_nxt;
  resp_t             resp_r, resp_nxt;
  logic [CODE_W-1:0] code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      resp_r  <= RS_DONE;
    end else begin
      state_r <= state_nxt;
      resp_r  <= resp_nxt;
    end
    if (state_r == S_IDLE) begin
      code_r <= in_command;
    end
  end

  // Sequencing of the datapath operations for each command.
  always_comb begin
    state_nxt = state_r;
    resp_nxt  = resp_r;
    cmd.op    = OP_NONE;
    cmd.scan  = SC_COUNT;
    cmd.resp  = resp_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLR;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (code_r)
          CMD_ADD: begin
            if (sts.full) begin
              resp_nxt  = RS_FULL;
              state_nxt = S_RESP;
            end else begin
              cmd.op    = OP_STORE;
              state_nxt = S_A_CNT;
            end
          end
          CMD_LOAD: begin
            resp_nxt  = sts.full ? RS_FULL : RS_DONE;
            cmd.op    = sts.full ? OP_NONE : OP_STORE;
            state_nxt = S_RESP;
          end
          CMD_RUN: begin
            cmd.op    = OP_RUN_INIT;
            state_nxt = S_R_TEST;
          end
          CMD_READ: begin
            resp_nxt  = sts.idx_bad ? RS_BADIDX : RS_READ;
            cmd.op    = sts.idx_bad ? OP_NONE : OP_RD_IDX;
            state_nxt = S_RESP;
          end
        endcase
      end
      S_A_CNT: begin
        cmd.op    = OP_SCAN;
        cmd.scan  = SC_COUNT;
        state_nxt = S_A_CW;
      end
      S_A_CW: begin
        if (!sts.scan_busy) begin
          if (sts.core) begin
            cmd.op    = OP_SCAN;
            cmd.scan  = SC_FIND;
            state_nxt = S_A_FW;
          end else begin
            cmd.op    = OP_NOISE_P;
            resp_nxt  = RS_NOISE;
            state_nxt = S_RESP;
          end
        end
      end
      S_A_FW: begin
        if (!sts.scan_busy) begin
          cmd.op    = OP_PICK;
          state_nxt = S_A_AP;
        end
      end
      S_A_AP: begin
        cmd.op    = OP_SCAN;
        cmd.scan  = SC_APPLY;
        state_nxt = S_A_AW;
      end
      S_A_AW: begin
        if (!sts.scan_busy) begin
          resp_nxt  = RS_CORE;
          state_nxt = S_RESP;
        end
      end
      S_R_TEST: begin
        if (sts.p_done) begin
          cmd.op    = OP_RUN_END;
          resp_nxt  = RS_DONE;
          state_nxt = S_RESP;
        end else begin
          cmd.op    = OP_RD_P;
          state_nxt = S_R_LD;
        end
      end
      S_R_LD: begin
        if (sts.uncl) begin
          cmd.op    = OP_LD_REF;
          state_nxt = S_R_CNT;
        end else begin
          cmd.op    = OP_NEXT_P;
          state_nxt = S_R_TEST;
        end
      end
      S_R_CNT: begin
        cmd.op    = OP_SCAN;
        cmd.scan  = SC_COUNT;
        state_nxt = S_R_CW;
      end
      S_R_CW: begin
        if (!sts.scan_busy) begin
          if (sts.core) begin
            cmd.op    = OP_SCAN;
            cmd.scan  = SC_SEED;
            state_nxt = S_R_SW;
          end else begin
            cmd.op    = OP_NOISE_P;
            state_nxt = S_R_TEST;
          end
        end
      end
      S_R_SW: begin
        if (!sts.scan_busy) begin
          state_nxt = S_R_QT;
        end
      end
      S_R_QT: begin
        if (sts.q_done) begin
          cmd.op    = OP_ID_NEXT;
          state_nxt = S_R_TEST;
        end else begin
          cmd.op    = OP_RD_Q;
          state_nxt = S_R_QS;
        end
      end
      S_R_QS: begin
        cmd.op    = OP_RD_S;
        state_nxt = S_R_QL;
      end
      S_R_QL: begin
        cmd.op    = OP_LD_REF;
        state_nxt = S_R_QC;
      end
      S_R_QC: begin
        cmd.op    = OP_SCAN;
        cmd.scan  = SC_COUNT;
        state_nxt = S_R_QCW;
      end
      S_R_QCW: begin
        if (!sts.scan_busy) begin
          if (sts.core) begin
            cmd.op    = OP_SCAN;
            cmd.scan  = SC_EXPAND;
            state_nxt = S_R_QEW;
          end else begin
            state_nxt = S_R_QT;
          end
        end
      end
      S_R_QEW: begin
        if (!sts.scan_busy) begin
          state_nxt = S_R_QT;
        end
      end
      S_RESP: begin
        cmd.op    = OP_RESP;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  // A command is only taken up from idle.
  a_capture_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECODE) |-> ($past(state_r) == S_IDLE)) else $error("decode not from idle");

  // Every result leaves the controller idle on the next cycle.
  a_resp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) |=> (state_r == S_IDLE)) else $error("response not followed by idle");

  // Passes are only waited on while one is running or has just been issued.
  a_scan_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_SCAN) |=> sts.scan_busy) else $error("pass did not start");

endmodule

/* rtl/density_cluster_point_labeler_top.sv */
// Channel   Ports                                         Transfer
// command   start, busy, in_command, in_coord_*,          start high while busy low
//           in_point_index
// result    out_strobe, out_status .. out_point_count     out_strobe high, one cycle
// config    cfg_we, cfg_index, cfg_wdata                  cfg_we high
//
// Each pass over the N stored points runs through a three-stage compare pipeline fed
// by the coordinate and label memories. Add takes a count pass, plus find and apply
// passes when the point is core. The result strobe rises in the cycle busy falls.
// Run takes a count pass per unclassified point, a seed pass per core one, and per
// queued seed a count pass plus an expand pass when the seed is core.
// After reset the merge-mark memory is cleared, busy high.
// The receiver cannot stall: a result is shown for exactly one cycle.
module density_cluster_point_labeler_top #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [dclab_pkg::CODE_W-1:0]         in_command,
  input  logic signed [COORD_BITS-1:0]         in_coord_x,
  input  logic signed [COORD_BITS-1:0]         in_coord_y,
  input  logic signed [COORD_BITS-1:0]         in_coord_z,
  input  logic [dclab_pkg::IDX_W-1:0]          in_point_index,
  input  logic                                 cfg_we,
  input  logic [dclab_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dclab_pkg::EPS_W-1:0]          cfg_wdata,
  output logic                                 out_strobe,
  output logic [dclab_pkg::CODE_W-1:0]         out_status,
  output logic [dclab_pkg::CODE_W-1:0]         out_label_class,
  output logic [dclab_pkg::OUT_W-1:0]          out_cluster_id,
  output logic [dclab_pkg::OUT_W-1:0]          out_cluster_count,
  output logic [dclab_pkg::OUT_W-1:0]          out_point_count
);
  import dclab_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Command sequencer.
  dclab_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_command(in_command),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  // Point store, compare pipeline and result registers.
  dclab_datapath #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_datapath (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .in_point_index(in_point_index), .cmd(cmd), .sts(sts),
    .out_strobe(out_strobe), .out_status(out_status), .out_label_class(out_label_class),
    .out_cluster_id(out_cluster_id), .out_cluster_count(out_cluster_count),
    .out_point_count(out_point_count)
  );

endmodule
